### design/pci_pkg.sv
// ----------------------------------------------------------------------------
// pci_pkg
// Shared types and constants for the permutation compose/invert block.
// ----------------------------------------------------------------------------
package pci_pkg;

  localparam int MAX_ELEMENTS = 256;
  localparam int ADDR_W       = 8;
  localparam int DATA_W       = 8;
  localparam int SIZE_W       = 9;
  localparam int RAM_DEPTH    = 1 << ADDR_W;

  // largest element count that can be in use
  localparam logic [SIZE_W-1:0] ACTIVE_MAX =
    SIZE_W'((MAX_ELEMENTS < RAM_DEPTH) ? MAX_ELEMENTS : RAM_DEPTH);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

  localparam logic [2:0] ACT_WRITE_WORK  = 3'd0;
  localparam logic [2:0] ACT_WRITE_OTHER = 3'd1;
  localparam logic [2:0] ACT_COMPOSE     = 3'd2;
  localparam logic [2:0] ACT_INVERT      = 3'd3;
  localparam logic [2:0] ACT_DIFFERENCE  = 3'd4;
  localparam logic [2:0] ACT_READ        = 3'd5;
  localparam logic [2:0] ACT_SWAP        = 3'd6;
  localparam logic [2:0] ACT_IDENTITY    = 3'd7;

  localparam logic REG_PERM_SIZE = 1'b0;

  typedef enum logic [1:0] {
    PASS_FILL,     // working[k] = k
    PASS_COPY,     // alt 0: scratch -> working, alt 1: other -> scratch
    PASS_SCATTER,  // alt 0: inverse of working, alt 1: of other, into scratch
    PASS_MAP       // alt 0: working through other, alt 1: through scratch
  } pass_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_MAP,
    ST_INV_SCAT,
    ST_INV_COPY,
    ST_DIF_COPY,
    ST_DIF_SCAT,
    ST_DIF_MAP
  } state_t;

  typedef struct packed {
    logic  wr_work;
    logic  wr_other;
    logic  rd_issue;
    logic  swap;
    logic  pass_start;
    pass_t pass_kind;
    logic  pass_alt;
    logic  load;
    logic  load_read;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } status_t;

endpackage

### design/permutation_compose_invert_top.sv
// ----------------------------------------------------------------------------
// permutation_compose_invert_top
// Working/other permutation stores with compose, invert and difference.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries action, position, value.
//   Result channel (res_valid/res_stall) returns one read_value per request.
//   perm_size is written over the APB port at address 0 while idle.
// Element actions cover n entries (perm_size clamped to 256):
//   Each element action is a chain of passes over the stores, one element
//   per cycle, pipelined through the registered read port of each RAM.
//   One request is in flight at a time; the next is taken once the result
//   is in the output register and that result is not stalled.
// Reset: perm_size returns to 256, sequencer idle, result channel empty.
//   Store contents are undefined until written.
// A stalled result holds; new requests stall until it drains.
// ----------------------------------------------------------------------------
module permutation_compose_invert_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [2:0]                    action,
  input  logic [pci_pkg::ADDR_W-1:0]    position,
  input  logic [pci_pkg::DATA_W-1:0]    value,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [pci_pkg::DATA_W-1:0]    read_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [pci_pkg::SIZE_W-1:0] perm_size;
  pci_pkg::cmd_t              cmd;
  pci_pkg::status_t           status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_size <= pci_pkg::SIZE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == pci_pkg::REG_PERM_SIZE) begin
      perm_size <= pwdata[pci_pkg::SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == pci_pkg::REG_PERM_SIZE) ?
                  {{(32 - pci_pkg::SIZE_W){1'b0}}, perm_size} : '0;

  pci_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .action    (action),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd),
    .status    (status)
  );

  pci_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .perm_size  (perm_size),
    .position   (position),
    .value      (value),
    .read_value (read_value)
  );

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |-> !status.busy)
    else $error("request accepted while a pass is running");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.pass_start |-> !status.busy)
    else $error("pass started while engine busy");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(res_valid && res_stall))
    else $error("result loaded over a stalled result");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && action == pci_pkg::ACT_READ) |=> (cmd.load && cmd.load_read))
    else $error("read request did not load its result");
`endif

endmodule

### design/pci_ram.sv
// ----------------------------------------------------------------------------
// pci_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/pci_datapath.sv
// ----------------------------------------------------------------------------
// pci_datapath
// Three permutation stores, the element pass engine and the result register.
// ----------------------------------------------------------------------------
module pci_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  pci_pkg::cmd_t                 cmd,
  output pci_pkg::status_t              status,
  input  logic [pci_pkg::SIZE_W-1:0]    perm_size,
  input  logic [pci_pkg::ADDR_W-1:0]    position,
  input  logic [pci_pkg::DATA_W-1:0]    value,
  output logic [pci_pkg::DATA_W-1:0]    read_value
);

  localparam int AW = pci_pkg::ADDR_W;
  localparam int DW = pci_pkg::DATA_W;
  localparam int SW = pci_pkg::SIZE_W;

  logic [SW-1:0] n;
  assign n = (perm_size > pci_pkg::ACTIVE_MAX) ? pci_pkg::ACTIVE_MAX : perm_size;

  // which physical RAM holds the working store; swap just flips it
  logic sel;

  // pass engine
  logic           running;
  logic [SW-1:0]  cnt;
  pci_pkg::pass_t kind;
  logic           alt;
  logic           v1, v2, inr2;
  logic [AW-1:0]  k1, k2;
  logic           issue;
  logic           rd_ok;
  logic           pos_ok;

  logic [AW-1:0] w_raddr, o_raddr, s_raddr;
  logic          w_we, o_we, s_we;
  logic [AW-1:0] w_waddr, o_waddr, s_waddr;
  logic [DW-1:0] w_wdata, o_wdata, s_wdata;
  logic [DW-1:0] w_rdata, o_rdata, s_rdata;
  logic [DW-1:0] r0_rdata, r1_rdata;
  logic [DW-1:0] t1;

  assign issue  = running && (cnt < n);
  assign pos_ok = ({1'b0, position} < n);
  assign status.busy = running | v1 | v2;

  always_comb begin
    w_raddr = '0; o_raddr = '0; s_raddr = '0;
    w_we = 1'b0;  o_we = 1'b0;  s_we = 1'b0;
    w_waddr = '0; o_waddr = '0; s_waddr = '0;
    w_wdata = '0; o_wdata = '0; s_wdata = '0;
    t1 = (alt && kind == pci_pkg::PASS_SCATTER) ? o_rdata : w_rdata;

    if (cmd.wr_work) begin
      w_we    = pos_ok;
      w_waddr = position;
      w_wdata = value;
    end
    if (cmd.wr_other) begin
      o_we    = pos_ok;
      o_waddr = position;
      o_wdata = value;
    end
    if (cmd.rd_issue) begin
      w_raddr = position;
    end

    case (kind)
      pci_pkg::PASS_FILL: begin
        if (issue) begin
          w_we    = 1'b1;
          w_waddr = cnt[AW-1:0];
          w_wdata = cnt[DW-1:0];
        end
      end
      pci_pkg::PASS_COPY: begin
        if (issue) begin
          if (alt) o_raddr = cnt[AW-1:0];
          else     s_raddr = cnt[AW-1:0];
        end
        if (v1) begin
          if (alt) begin
            s_we    = 1'b1;
            s_waddr = k1;
            s_wdata = o_rdata;
          end else begin
            w_we    = 1'b1;
            w_waddr = k1;
            w_wdata = s_rdata;
          end
        end
      end
      pci_pkg::PASS_SCATTER: begin
        if (issue) begin
          if (alt) o_raddr = cnt[AW-1:0];
          else     w_raddr = cnt[AW-1:0];
        end
        if (v1 && ({1'b0, t1} < n)) begin
          s_we    = 1'b1;
          s_waddr = t1;
          s_wdata = k1;
        end
      end
      pci_pkg::PASS_MAP: begin
        if (issue) begin
          w_raddr = cnt[AW-1:0];
        end
        if (v1) begin
          if (alt) s_raddr = w_rdata;
          else     o_raddr = w_rdata;
        end
        if (v2) begin
          w_we    = 1'b1;
          w_waddr = k2;
          w_wdata = inr2 ? (alt ? s_rdata : o_rdata) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel     <= 1'b0;
      running <= 1'b0;
      cnt     <= '0;
      kind    <= pci_pkg::PASS_FILL;
      alt     <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      if (cmd.swap) begin
        sel <= ~sel;
      end
      if (cmd.pass_start) begin
        running <= 1'b1;
        cnt     <= '0;
        kind    <= cmd.pass_kind;
        alt     <= cmd.pass_alt;
      end else if (issue) begin
        cnt <= cnt + SW'(1);
      end else begin
        running <= 1'b0;
      end
      v1 <= issue;
      v2 <= v1 && (kind == pci_pkg::PASS_MAP);
    end
  end

  always_ff @(posedge clk) begin
    k1   <= cnt[AW-1:0];
    k2   <= k1;
    inr2 <= ({1'b0, w_rdata} < n);
    if (cmd.rd_issue) begin
      rd_ok <= pos_ok;
    end
    if (cmd.load) begin
      read_value <= (cmd.load_read && rd_ok) ? w_rdata : '0;
    end
  end

  assign w_rdata = sel ? r1_rdata : r0_rdata;
  assign o_rdata = sel ? r0_rdata : r1_rdata;

  pci_ram #(.WIDTH(DW), .DEPTH(pci_pkg::RAM_DEPTH)) u_ram0 (
    .clk   (clk),
    .we    (sel ? o_we : w_we),
    .waddr (sel ? o_waddr : w_waddr),
    .wdata (sel ? o_wdata : w_wdata),
    .raddr (sel ? o_raddr : w_raddr),
    .rdata (r0_rdata)
  );

  pci_ram #(.WIDTH(DW), .DEPTH(pci_pkg::RAM_DEPTH)) u_ram1 (
    .clk   (clk),
    .we    (sel ? w_we : o_we),
    .waddr (sel ? w_waddr : o_waddr),
    .wdata (sel ? w_wdata : o_wdata),
    .raddr (sel ? w_raddr : o_raddr),
    .rdata (r1_rdata)
  );

  pci_ram #(.WIDTH(DW), .DEPTH(pci_pkg::RAM_DEPTH)) u_scratch (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

endmodule

### design/pci_ctrl.sv
// ----------------------------------------------------------------------------
// pci_ctrl
// Request sequencer: accepts requests, chains element passes, issues results.
// ----------------------------------------------------------------------------
module pci_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic [2:0]       action,
  output logic             res_valid,
  input  logic             res_stall,
  output pci_pkg::cmd_t    cmd,
  input  pci_pkg::status_t status
);

  pci_pkg::state_t state, state_next;
  logic            res_valid_next;
  logic            accept;

  assign req_stall = (state != pci_pkg::ST_IDLE) || (res_valid && res_stall);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    state_next = state;
    case (state)
      pci_pkg::ST_IDLE: begin
        if (accept) begin
          case (action)
            pci_pkg::ACT_COMPOSE:    state_next = pci_pkg::ST_MAP;
            pci_pkg::ACT_INVERT:     state_next = pci_pkg::ST_INV_SCAT;
            pci_pkg::ACT_DIFFERENCE: state_next = pci_pkg::ST_DIF_COPY;
            pci_pkg::ACT_READ:       state_next = pci_pkg::ST_READ;
            pci_pkg::ACT_IDENTITY:   state_next = pci_pkg::ST_FILL;
            default:                 state_next = pci_pkg::ST_IDLE;
          endcase
        end
      end
      pci_pkg::ST_READ: state_next = pci_pkg::ST_IDLE;
      pci_pkg::ST_FILL, pci_pkg::ST_MAP, pci_pkg::ST_INV_COPY,
      pci_pkg::ST_DIF_MAP: begin
        if (!status.busy) state_next = pci_pkg::ST_IDLE;
      end
      pci_pkg::ST_INV_SCAT: begin
        if (!status.busy) state_next = pci_pkg::ST_INV_COPY;
      end
      pci_pkg::ST_DIF_COPY: begin
        if (!status.busy) state_next = pci_pkg::ST_DIF_SCAT;
      end
      pci_pkg::ST_DIF_SCAT: begin
        if (!status.busy) state_next = pci_pkg::ST_DIF_MAP;
      end
      default: state_next = pci_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.pass_kind = pci_pkg::PASS_FILL;
    case (state)
      pci_pkg::ST_IDLE: begin
        if (accept) begin
          case (action)
            pci_pkg::ACT_WRITE_WORK: begin
              cmd.wr_work = 1'b1;
              cmd.load    = 1'b1;
            end
            pci_pkg::ACT_WRITE_OTHER: begin
              cmd.wr_other = 1'b1;
              cmd.load     = 1'b1;
            end
            pci_pkg::ACT_COMPOSE: begin
              cmd.pass_start = 1'b1;
              cmd.pass_kind  = pci_pkg::PASS_MAP;
            end
            pci_pkg::ACT_INVERT: begin
              cmd.pass_start = 1'b1;
              cmd.pass_kind  = pci_pkg::PASS_SCATTER;
            end
            pci_pkg::ACT_DIFFERENCE: begin
              cmd.pass_start = 1'b1;
              cmd.pass_kind  = pci_pkg::PASS_COPY;
              cmd.pass_alt   = 1'b1;
            end
            pci_pkg::ACT_READ: cmd.rd_issue = 1'b1;
            pci_pkg::ACT_SWAP: begin
              cmd.swap = 1'b1;
              cmd.load = 1'b1;
            end
            pci_pkg::ACT_IDENTITY: begin
              cmd.pass_start = 1'b1;
              cmd.pass_kind  = pci_pkg::PASS_FILL;
            end
            default: begin
            end
          endcase
        end
      end
      pci_pkg::ST_READ: begin
        cmd.load      = 1'b1;
        cmd.load_read = 1'b1;
      end
      pci_pkg::ST_FILL, pci_pkg::ST_MAP, pci_pkg::ST_INV_COPY,
      pci_pkg::ST_DIF_MAP: begin
        cmd.load = !status.busy;
      end
      pci_pkg::ST_INV_SCAT: begin
        cmd.pass_start = !status.busy;
        cmd.pass_kind  = pci_pkg::PASS_COPY;
      end
      pci_pkg::ST_DIF_COPY: begin
        cmd.pass_start = !status.busy;
        cmd.pass_kind  = pci_pkg::PASS_SCATTER;
        cmd.pass_alt   = 1'b1;
      end
      pci_pkg::ST_DIF_SCAT: begin
        cmd.pass_start = !status.busy;
        cmd.pass_kind  = pci_pkg::PASS_MAP;
        cmd.pass_alt   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result slot is free or draining whenever a load happens
  assign res_valid_next = cmd.load ? 1'b1 : (res_valid && res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pci_pkg::ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

### tb/perm_store_checker.sv
// ----------------------------------------------------------------------------
// perm_store_checker
// Watches the request, result and APB channels of the permutation block.
// Keeps its own copy of the working, other and scratch stores and of
// perm_size. Each accepted request is applied to that copy, and the read
// value it should return is queued. Each accepted result is compared
// against the oldest queued value.
// ----------------------------------------------------------------------------
module perm_store_checker
  import pci_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  logic [2:0]        action,
  input  logic [ADDR_W-1:0] position,
  input  logic [DATA_W-1:0] value,
  input  logic              res_valid,
  input  logic              res_stall,
  input  logic [DATA_W-1:0] read_value,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                pending,
  output int                errors
);

  localparam logic [2:0] PERM_SIZE_ADDR = {REG_PERM_SIZE, 2'b00};

  typedef struct packed {
    logic [2:0]        act;
    logic [ADDR_W-1:0] pos;
    logic [DATA_W-1:0] rd;
  } read_due_t;

  logic [DATA_W-1:0] work_tbl    [RAM_DEPTH];
  logic [DATA_W-1:0] other_tbl   [RAM_DEPTH];
  logic [DATA_W-1:0] scratch_tbl [RAM_DEPTH];
  logic [SIZE_W-1:0] size_cfg = SIZE_RESET;
  read_due_t         reads_due [$];
  int                mismatches = 0;
  int                unexpected = 0;
  int                reported   = 0;

  task automatic apply_perm_action(input logic [2:0] act, input logic [ADDR_W-1:0] pos,
                                   input logic [DATA_W-1:0] val,
                                   output logic [DATA_W-1:0] rd);
    int n;
    int k;
    int t;
    logic [DATA_W-1:0] hold;
    n  = (int'(size_cfg) > int'(ACTIVE_MAX)) ? int'(ACTIVE_MAX) : int'(size_cfg);
    rd = '0;
    case (act)
      ACT_WRITE_WORK: begin
        if (int'(pos) < n) work_tbl[pos] = val;
      end
      ACT_WRITE_OTHER: begin
        if (int'(pos) < n) other_tbl[pos] = val;
      end
      ACT_COMPOSE: begin
        for (k = 0; k < n; k++) begin
          t = int'(work_tbl[k]);
          work_tbl[k] = (t < n) ? other_tbl[t] : '0;
        end
      end
      ACT_INVERT: begin
        // untargeted entries keep whatever scratch held
        for (k = 0; k < n; k++) begin
          t = int'(work_tbl[k]);
          if (t < n) scratch_tbl[t] = DATA_W'(k);
        end
        for (k = 0; k < n; k++) work_tbl[k] = scratch_tbl[k];
      end
      ACT_DIFFERENCE: begin
        // inverse of other built over a copy of other
        for (k = 0; k < n; k++) scratch_tbl[k] = other_tbl[k];
        for (k = 0; k < n; k++) begin
          t = int'(other_tbl[k]);
          if (t < n) scratch_tbl[t] = DATA_W'(k);
        end
        for (k = 0; k < n; k++) begin
          t = int'(work_tbl[k]);
          work_tbl[k] = (t < n) ? scratch_tbl[t] : '0;
        end
      end
      ACT_READ: begin
        if (int'(pos) < n) rd = work_tbl[pos];
      end
      ACT_SWAP: begin
        // whole store, regardless of size
        for (k = 0; k < RAM_DEPTH; k++) begin
          hold         = work_tbl[k];
          work_tbl[k]  = other_tbl[k];
          other_tbl[k] = hold;
        end
      end
      ACT_IDENTITY: begin
        for (k = 0; k < n; k++) work_tbl[k] = DATA_W'(k);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    read_due_t         due;
    logic [DATA_W-1:0] rd;
    if (rst) begin
      size_cfg = SIZE_RESET;
      reads_due.delete();
      pending <= 0;
      errors  <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == PERM_SIZE_ADDR)
        size_cfg = pwdata[SIZE_W-1:0];
      if (res_valid && !res_stall) begin
        if (reads_due.size() == 0) begin
          unexpected++;
          if (reported < 10) begin
            reported++;
            $display("[%0t] result with no request pending: read_value=%0d",
                     $realtime, read_value);
          end
        end else begin
          due = reads_due.pop_front();
          if (read_value !== due.rd) begin
            mismatches++;
            if (reported < 10) begin
              reported++;
              $display("[%0t] read_value mismatch (action %0d, position %0d): expected %0d, got %0d",
                       $realtime, due.act, due.pos, due.rd, read_value);
            end
          end
        end
      end
      if (req_valid && !req_stall) begin
        apply_perm_action(action, position, value, rd);
        reads_due.push_back('{act: action, pos: position, rd: rd});
      end
      pending <= reads_due.size();
      errors  <= mismatches + unexpected + reads_due.size();
    end
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for permutation_compose_invert_top. Loads both stores
// with identities first, runs a directed pass over the size corner cases,
// then random phases: each sets perm_size and mixes random permutation loads,
// compose, invert, difference, swap, identity, noise writes and reads.
// Sender and receiver idle at random; one long receiver hold-off fills the
// block. The checker instance predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import pci_pkg::*;

  localparam int         IDLE_LIMIT     = 6000;
  localparam int         ITEM_TARGET    = 600;
  localparam logic [2:0] PERM_SIZE_ADDR = {REG_PERM_SIZE, 2'b00};

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic [2:0]        action    = ACT_READ;
  logic [ADDR_W-1:0] position  = '0;
  logic [DATA_W-1:0] value     = '0;
  logic              res_valid;
  logic              res_stall = 1'b1;
  logic [DATA_W-1:0] read_value;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [2:0]        paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  int pending;
  int errors;
  int n_eff       = 256;
  int useful      = 0;
  int quiet       = 0;
  int stall_burst = 0;
  bit no_idle     = 1'b0;

  always #10 clk = ~clk;

  permutation_compose_invert_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .action(action), .position(position), .value(value),
    .res_valid(res_valid), .res_stall(res_stall), .read_value(read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  perm_store_checker u_check (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .action(action), .position(position), .value(value),
    .res_valid(res_valid), .res_stall(res_stall), .read_value(read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .pending(pending), .errors(errors)
  );

  function automatic logic [7:0] any_byte();
    return 8'($urandom());
  endfunction

  task automatic send_request(input logic [2:0] act, input logic [7:0] pos,
                              input logic [7:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    action    <= act;
    position  <= pos;
    value     <= val;
    do @(posedge clk); while (req_stall);
    if (!((act == ACT_WRITE_WORK || act == ACT_WRITE_OTHER) && int'(pos) >= n_eff))
      useful++;
  endtask

  // drain: every request answered
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_perm_size(input logic [31:0] word);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PERM_SIZE_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_eff = (int'(word[SIZE_W-1:0]) > int'(ACTIVE_MAX)) ? int'(ACTIVE_MAX)
                                                         : int'(word[SIZE_W-1:0]);
  endtask

  task automatic sample_working(input int cnt);
    logic [7:0] pos;
    repeat (cnt) begin
      pos = (n_eff == 0 || $urandom_range(0, 7) == 0) ? any_byte()
                                                      : 8'($urandom_range(0, n_eff - 1));
      send_request(ACT_READ, pos, any_byte());
    end
  endtask

  // small sizes: shuffled full load; large: identity plus one transposition
  task automatic load_random_perm(input logic [2:0] wr_act);
    int order [RAM_DEPTH];
    int i;
    int j;
    int tmp;
    int a;
    int b;
    if (n_eff == 0) return;
    if (n_eff <= 32) begin
      for (i = 0; i < n_eff; i++) order[i] = i;
      for (i = n_eff - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (i = 0; i < n_eff; i++) send_request(wr_act, 8'(i), 8'(order[i]));
    end else begin
      if (wr_act == ACT_WRITE_OTHER) send_request(ACT_SWAP, any_byte(), any_byte());
      send_request(ACT_IDENTITY, any_byte(), any_byte());
      a = $urandom_range(0, n_eff - 1);
      b = $urandom_range(0, n_eff - 1);
      send_request(ACT_WRITE_WORK, 8'(a), 8'(b));
      send_request(ACT_WRITE_WORK, 8'(b), 8'(a));
      if (wr_act == ACT_WRITE_OTHER) send_request(ACT_SWAP, any_byte(), any_byte());
    end
  endtask

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : result_sink
    int w;
    forever begin
      if (stall_burst > 0) begin
        res_stall <= 1'b1;
        repeat (stall_burst) @(posedge clk);
        stall_burst = 0;
      end
      w = no_idle ? 0 : $urandom_range(0, 3);
      if (w > 0) begin
        res_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
    end
  end

  initial begin : stimulus
    int          phase;
    int          steps;
    int          size;
    int          r;
    logic [31:0] word;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // define every entry of all three stores before anything reads them
    send_request(ACT_IDENTITY, 8'd0, 8'd0);
    send_request(ACT_SWAP, 8'hff, 8'hff);
    send_request(ACT_IDENTITY, 8'hff, 8'h00);
    send_request(ACT_DIFFERENCE, 8'h00, 8'hff);

    send_request(ACT_WRITE_WORK, 8'd0, 8'd255);
    send_request(ACT_WRITE_WORK, 8'd255, 8'd0);
    send_request(ACT_WRITE_OTHER, 8'd0, 8'd1);
    send_request(ACT_WRITE_OTHER, 8'd1, 8'd0);
    send_request(ACT_COMPOSE, 8'd0, 8'd0);
    send_request(ACT_READ, 8'd0, 8'd0);
    send_request(ACT_INVERT, 8'd0, 8'd0);
    send_request(ACT_DIFFERENCE, 8'd0, 8'd0);
    send_request(ACT_READ, 8'd255, 8'd0);

    // position and element values beyond the size, repeated values
    write_perm_size(32'd4);
    send_request(ACT_WRITE_WORK, 8'd200, 8'd1);
    send_request(ACT_READ, 8'd200, 8'd0);
    send_request(ACT_WRITE_WORK, 8'd0, 8'd9);
    send_request(ACT_WRITE_OTHER, 8'd2, 8'd0);
    send_request(ACT_COMPOSE, 8'd0, 8'd0);
    send_request(ACT_INVERT, 8'd0, 8'd0);
    send_request(ACT_DIFFERENCE, 8'd0, 8'd0);
    send_request(ACT_READ, 8'd1, 8'd0);

    write_perm_size(32'd0);
    send_request(ACT_WRITE_WORK, 8'd0, 8'd0);
    send_request(ACT_READ, 8'd0, 8'd0);

    write_perm_size(32'd1);
    send_request(ACT_INVERT, 8'd0, 8'd0);
    send_request(ACT_READ, 8'd0, 8'd0);

    // saturates to the full store
    write_perm_size(32'd511);
    send_request(ACT_IDENTITY, 8'd0, 8'd0);
    send_request(ACT_READ, 8'd255, 8'd0);

    useful = 0;
    phase  = 0;
    while (useful < ITEM_TARGET) begin
      r = $urandom_range(0, 19);
      if (phase == 0)  size = 8;
      else if (r == 0) size = 256;
      else if (r == 1) size = 0;
      else if (r == 2) size = $urandom_range(257, 511);
      else if (r < 5)  size = $urandom_range(17, 64);
      else             size = $urandom_range(1, 16);
      word = $urandom();
      word[SIZE_W-1:0] = SIZE_W'(size);
      write_perm_size(word);
      no_idle = ($urandom_range(0, 3) == 0);
      // receiver holds off while requests keep coming
      if (phase == 0) stall_burst = 300;
      steps = $urandom_range(6, 20);
      repeat (steps) begin
        case ($urandom_range(0, 11))
          0, 1: load_random_perm(ACT_WRITE_WORK);
          2:    load_random_perm(ACT_WRITE_OTHER);
          3: begin
            send_request(ACT_COMPOSE, any_byte(), any_byte());
            sample_working(2);
          end
          4: begin
            send_request(ACT_INVERT, any_byte(), any_byte());
            sample_working(2);
          end
          5: begin
            send_request(ACT_DIFFERENCE, any_byte(), any_byte());
            sample_working(2);
          end
          6:    send_request(ACT_SWAP, any_byte(), any_byte());
          7:    send_request(ACT_IDENTITY, any_byte(), any_byte());
          8, 9: sample_working($urandom_range(1, 4));
          10: begin
            send_request(($urandom_range(0, 1) == 0) ? ACT_WRITE_WORK : ACT_WRITE_OTHER,
                         any_byte(), any_byte());
          end
          default: send_request(3'($urandom_range(0, 7)), any_byte(), any_byte());
        endcase
      end
      phase++;
    end

    no_idle = 1'b0;
    settle();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
